/* src/wavetable_sound_ram_channel_step_top_assert.svh */
// Assertion macros shared by the wavetable sound checker.
`ifndef WAVETABLE_SOUND_RAM_CHANNEL_STEP_TOP_ASSERT_SVH
`define WAVETABLE_SOUND_RAM_CHANNEL_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WTSND_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("wtsnd check failed");

// Next-cycle implication, disabled during reset.
`define WTSND_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("wtsnd check failed");

`endif

/* src/wtsnd_pkg.sv */
// Types and constants of the wavetable sound unit.
`default_nettype none
package wtsnd_pkg;

   localparam int RAM_BYTES = 128;
   localparam int ADDR_W    = $clog2(RAM_BYTES);

   // word kinds on the request channel
   localparam logic [1:0] KIND_DATA_WR = 2'd0;
   localparam logic [1:0] KIND_ADDR_WR = 2'd1;
   localparam logic [1:0] KIND_DATA_RD = 2'd2;
   localparam logic [1:0] KIND_TICK    = 2'd3;

   // byte holding the active channel count in bits 6:4
   localparam logic [ADDR_W-1:0] CH_COUNT_ADDR = 7'h7F;
   localparam logic [2:0]        CH_TOP        = 3'd7;

   // offsets inside one channel block
   localparam logic [2:0] OFS_PHASE0 = 3'd1;
   localparam logic [2:0] OFS_PHASE1 = 3'd3;
   localparam logic [2:0] OFS_PHASE2 = 3'd5;

   localparam logic [7:0] LEN_MASK     = 8'hFC;
   localparam logic [7:0] FREQ_HI_MASK = 8'h03;

   // shared adder and remainder stepping
   localparam int ALU_W     = 16;
   localparam int LEN_W     = 9;
   localparam int DIV_STEPS = 7;
   localparam int DIV_W     = LEN_W + DIV_STEPS - 1;
   localparam logic [ALU_W-1:0] LEN_BASE = 16'd256;

   typedef struct packed {
      logic              re;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             inv;
      logic             cin;
   } alu_req_type;

endpackage
`default_nettype wire

/* src/wavetable_sound_ram_channel_step_top.sv */
// Top level of the wavetable sound unit: request sequencer and result register.
//
// Request channel (req_*): one word per access. req_tuser selects the kind:
// data port write, address port write, data port read or channel tick.
// req_tdata carries the byte (address writes: bit 7 auto-increment, 6:0 pointer).
// Result channel (rsp_*): one word for each read and each tick, none for writes.
// Steps of a word: a write is done at accept; a read is accepted, then output; a tick
// is accepted, fetches the 8 block bytes, takes 7 remainder steps of the shared adder,
// does 3 phase write-backs, fetches 1 wave sample and then outputs its word. The
// single RAM port and the shared adder set this sequence; one word is in work at a time.
// The result register sits between the sequencer and rsp_*, so a new request is
// taken while a result still waits; a stalled result holds its word, and the
// sequencer only waits at its last step if the register is still full.
// Reset (synchronous, active high) clears the pointer, the channel counter and the
// result valid, and sets the lowest active channel to 7; the 128 RAM bytes read as
// zero until written, through one valid bit per byte, so no clearing pass is needed.
`default_nettype none
module wavetable_sound_ram_channel_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] read_byte, [10:8] channel, [18:11] level
   output logic             rsp_tuser    // [0] is_sample
);
   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_FETCH = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_WR1   = 4'd4;
   localparam logic [3:0] ST_WR3   = 4'd5;
   localparam logic [3:0] ST_WR5   = 4'd6;
   localparam logic [3:0] ST_WAVE  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   localparam int AW = wtsnd_pkg::ADDR_W;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic        auto_ff, auto_in;
   logic [2:0]  ch_ff, ch_in;
   logic [2:0]  lowest_ff, lowest_in;
   logic [7:0]  fa_ff, fa_in;
   logic [7:0]  s0_ff, s0_in;
   logic [7:0]  s1_ff, s1_in;
   logic        carry_ff, carry_in;
   logic [wtsnd_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [wtsnd_pkg::DIV_W-1:0] div_ff, div_in;
   logic [7:0]  off_ff, off_in;
   logic [3:0]  vol_ff, vol_in;
   logic [7:0]  idx_ff, idx_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tuser_ff, rsp_tuser_in;

   wtsnd_pkg::mem_req_type mem_req;
   wtsnd_pkg::alu_req_type alu_req;
   logic [7:0]              rdata;
   logic [wtsnd_pkg::ALU_W:0] alu_sum;

   logic        out_free;
   logic [2:0]  ch_dec;
   logic [2:0]  ch_next;
   logic [3:0]  nib;
   logic signed [3:0] smp;
   logic signed [8:0] prod;
   logic [wtsnd_pkg::LEN_W-1:0] len;

   wtsnd_store u_store (
      .clock  (clock),
      .reset  (reset),
      .mem_req(mem_req),
      .rdata  (rdata)
   );

   wtsnd_alu u_alu (
      .alu_req(alu_req),
      .sum    (alu_sum)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // next channel: count down, wrap from the lowest active one back to 7
   assign ch_dec  = ch_ff - 3'd1;
   assign ch_next = (ch_dec < lowest_ff) ? wtsnd_pkg::CH_TOP : ch_dec;

   // sample nibble minus 8 is the nibble with its top bit flipped
   assign nib  = idx_ff[0] ? rdata[7:4] : rdata[3:0];
   assign smp  = {~nib[3], nib[2:0]};
   assign prod = smp * $signed({1'b0, vol_ff});
   assign len  = alu_sum[wtsnd_pkg::LEN_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      auto_in       = auto_ff;
      ch_in         = ch_ff;
      lowest_in     = lowest_ff;
      fa_in         = fa_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      carry_in      = carry_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      off_in        = off_ff;
      vol_in        = vol_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mem_req       = '0;
      alu_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  wtsnd_pkg::KIND_DATA_WR: begin
                     mem_req.we    = 1'b1;
                     mem_req.addr  = ptr_ff;
                     mem_req.wdata = req_tdata;
                     ptr_in        = ptr_ff + {{(AW-1){1'b0}}, auto_ff};
                     // only this byte holds the count; 7 - n is ~n on 3 bits
                     if (ptr_ff == wtsnd_pkg::CH_COUNT_ADDR) begin
                        lowest_in = ~req_tdata[6:4];
                     end
                  end
                  wtsnd_pkg::KIND_ADDR_WR: begin
                     ptr_in  = req_tdata[AW-1:0];
                     auto_in = req_tdata[7];
                  end
                  wtsnd_pkg::KIND_DATA_RD: begin
                     mem_req.re   = 1'b1;
                     mem_req.addr = ptr_ff;
                     ptr_in       = ptr_ff + {{(AW-1){1'b0}}, auto_ff};
                     state_in     = ST_READ;
                  end
                  wtsnd_pkg::KIND_TICK: begin
                     ch_in    = ch_next;
                     cnt_in   = '0;
                     state_in = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {16'h0000, rdata};
               rsp_tuser_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_FETCH: begin
            // read block byte cnt, handle byte cnt-1 that arrives now
            mem_req.re   = !cnt_ff[3];
            mem_req.addr = {1'b1, ch_ff, cnt_ff[2:0]};
            cnt_in       = cnt_ff + 4'd1;
            unique case (cnt_ff)
               4'd1, 4'd3: fa_in = rdata;   // frequency low and middle
               4'd2: begin
                  alu_req.a = {8'h00, rdata};
                  alu_req.b = {8'h00, fa_ff};
                  s0_in     = alu_sum[7:0];
                  carry_in  = alu_sum[8];
               end
               4'd4: begin
                  alu_req.a   = {8'h00, rdata};
                  alu_req.b   = {8'h00, fa_ff};
                  alu_req.cin = carry_ff;
                  s1_in       = alu_sum[7:0];
                  carry_in    = alu_sum[8];
               end
               4'd5: begin
                  // length = 256 - (byte & 0xFC); divisor starts at length << 6
                  fa_in       = rdata & wtsnd_pkg::FREQ_HI_MASK;
                  alu_req.a   = wtsnd_pkg::LEN_BASE;
                  alu_req.b   = {8'h00, rdata & wtsnd_pkg::LEN_MASK};
                  alu_req.inv = 1'b1;
                  alu_req.cin = 1'b1;
                  div_in      = {len, {(wtsnd_pkg::DIV_STEPS-1){1'b0}}};
               end
               4'd6: begin
                  alu_req.a   = {8'h00, rdata};
                  alu_req.b   = {8'h00, fa_ff};
                  alu_req.cin = carry_ff;
                  rem_in      = alu_sum[wtsnd_pkg::LEN_W-1:0];
               end
               4'd7: off_in = rdata;
               4'd8: begin
                  vol_in   = rdata[3:0];
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               default: begin
               end
            endcase
         end

         ST_DIV: begin
            // restoring remainder of the phase top bits by the length
            alu_req.a   = {{(wtsnd_pkg::ALU_W-wtsnd_pkg::LEN_W){1'b0}}, rem_ff};
            alu_req.b   = {{(wtsnd_pkg::ALU_W-wtsnd_pkg::DIV_W){1'b0}}, div_ff};
            alu_req.inv = 1'b1;
            alu_req.cin = 1'b1;
            if (alu_sum[wtsnd_pkg::ALU_W]) begin
               rem_in = alu_sum[wtsnd_pkg::LEN_W-1:0];
            end
            div_in = div_ff >> 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(wtsnd_pkg::DIV_STEPS - 1)) begin
               state_in = ST_WR1;
            end
         end

         ST_WR1: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = {1'b1, ch_ff, wtsnd_pkg::OFS_PHASE0};
            mem_req.wdata = s0_ff;
            // wave index = phase sample + offset, mod 256
            alu_req.a     = {8'h00, rem_ff[7:0]};
            alu_req.b     = {8'h00, off_ff};
            idx_in        = alu_sum[7:0];
            state_in      = ST_WR3;
         end

         ST_WR3: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = {1'b1, ch_ff, wtsnd_pkg::OFS_PHASE1};
            mem_req.wdata = s1_ff;
            state_in      = ST_WR5;
         end

         ST_WR5: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = {1'b1, ch_ff, wtsnd_pkg::OFS_PHASE2};
            mem_req.wdata = rem_ff[7:0];
            state_in      = ST_WAVE;
         end

         ST_WAVE: begin
            mem_req.re   = 1'b1;
            mem_req.addr = idx_ff[7:1];
            state_in     = ST_OUT;
         end

         ST_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'b00000, prod[7:0], ch_ff, 8'h00};
               rsp_tuser_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         ptr_ff        <= '0;
         auto_ff       <= 1'b0;
         ch_ff         <= 3'd0;
         lowest_ff     <= wtsnd_pkg::CH_TOP;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         auto_ff       <= auto_in;
         ch_ff         <= ch_in;
         lowest_ff     <= lowest_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      fa_ff        <= fa_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      carry_ff     <= carry_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      off_ff       <= off_in;
      vol_ff       <= vol_in;
      idx_ff       <= idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
endmodule
`default_nettype wire

/* src/wtsnd_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module wtsnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* src/wtsnd_store.sv */
// Sound RAM with per-byte valid bits so that reset reads as all zero.
`default_nettype none
module wtsnd_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wtsnd_pkg::mem_req_type mem_req,
   output logic [7:0]                rdata
);
   logic [wtsnd_pkg::RAM_BYTES-1:0] valid_ff;
   logic [wtsnd_pkg::RAM_BYTES-1:0] valid_in;
   logic                            rvalid_ff;
   logic [7:0]                      ram_rdata;

   wtsnd_ram #(
      .WIDTH(8),
      .DEPTH(wtsnd_pkg::RAM_BYTES)
   ) u_ram (
      .clock(clock),
      .we   (mem_req.we),
      .re   (mem_req.re),
      .addr (mem_req.addr),
      .wdata(mem_req.wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.we) begin
         valid_in[mem_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (mem_req.re) begin
            rvalid_ff <= valid_ff[mem_req.addr];
         end
      end
   end

   // a byte never written since reset reads as zero
   assign rdata = rvalid_ff ? ram_rdata : 8'h00;
endmodule
`default_nettype wire

/* src/wtsnd_alu.sv */
// Shared add/subtract unit used for phase add, length, remainder steps and wave index.
`default_nettype none
module wtsnd_alu (
   input  wire wtsnd_pkg::alu_req_type alu_req,
   output logic [wtsnd_pkg::ALU_W:0]   sum
);
   logic [wtsnd_pkg::ALU_W-1:0] b_eff;

   always_comb begin
      b_eff = alu_req.inv ? ~alu_req.b : alu_req.b;
      sum   = {1'b0, alu_req.a} + {1'b0, b_eff}
            + {{wtsnd_pkg::ALU_W{1'b0}}, alu_req.cin};
   end
endmodule
`default_nettype wire

/* src/wtsnd_checker.sv */
// Port-level checks of the wavetable sound unit, bound to its top level.
`default_nettype none
`include "wavetable_sound_ram_channel_step_top_assert.svh"
module wtsnd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   logic        busy_kind;
   logic        req_take;
   logic        rsp_stall;
   logic [24:0] rsp_word;
   logic        read_pad_ok;
   logic        tick_pad_ok;

   assign busy_kind = (req_tuser == wtsnd_pkg::KIND_DATA_RD)
                   || (req_tuser == wtsnd_pkg::KIND_TICK);
   assign req_take    = req_tvalid && req_tready && busy_kind;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign read_pad_ok = (rsp_tdata[23:8] == 16'h0000);
   assign tick_pad_ok = (rsp_tdata[7:0] == 8'h00) && (rsp_tdata[23:19] == 5'b00000);

   // a stalled result word holds
   `WTSND_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // read words carry no channel or level, sample words no read byte
   `WTSND_ASSERT_NOW(a_read_clean, clock, reset, rsp_tvalid && !rsp_tuser, read_pad_ok)
   `WTSND_ASSERT_NOW(a_tick_clean, clock, reset, rsp_tvalid && rsp_tuser, tick_pad_ok)

   // reads and ticks keep the sequencer busy for at least the next cycle
   `WTSND_ASSERT_NEXT(a_busy_after, clock, reset, req_take, !req_tready)
endmodule

bind wavetable_sound_ram_channel_step_top wtsnd_checker u_wtsnd_checker (.*);
`default_nettype wire

/* sim/wavetable_sound_ram_channel_step_top_test.sv */
// Self-checking testbench of the wavetable sound unit: directed table, then random port traffic.
`default_nettype none
module wavetable_sound_ram_channel_step_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One result word, unpacked from rsp_tdata / rsp_tuser.
   typedef struct packed {
      logic              is_sample;
      logic [7:0]        read_byte;
      logic [2:0]        channel;
      logic signed [7:0] level;
   } sound_word_type;

   // One stimulus word; typed rows carry a hand-written expectation.
   typedef struct packed {
      logic [1:0]     kind;
      logic [7:0]     data;
      logic           typed;
      sound_word_type word;
   } stim_row_type;

   // Word kinds and block offsets, short local names.
   localparam logic [1:0] DATA_WR = wtsnd_pkg::KIND_DATA_WR;
   localparam logic [1:0] ADDR_WR = wtsnd_pkg::KIND_ADDR_WR;
   localparam logic [1:0] DATA_RD = wtsnd_pkg::KIND_DATA_RD;
   localparam logic [1:0] TICK    = wtsnd_pkg::KIND_TICK;

   localparam logic [2:0] OFS_PHASE0 = wtsnd_pkg::OFS_PHASE0;
   localparam logic [2:0] OFS_PHASE1 = wtsnd_pkg::OFS_PHASE1;
   localparam logic [2:0] OFS_PHASE2 = wtsnd_pkg::OFS_PHASE2;

   // Channel block offsets not named in the package.
   localparam logic [2:0] OFS_FREQ0  = 3'd0;
   localparam logic [2:0] OFS_FREQ1  = 3'd2;
   localparam logic [2:0] OFS_LENGTH = 3'd4;
   localparam logic [2:0] OFS_WAVE   = 3'd6;
   localparam logic [2:0] OFS_VOLUME = 3'd7;
   localparam logic [6:0] CH_BLOCKS  = 7'h40;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_WORDS  = 925;
   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_CYCLES  = 40;

   localparam sound_word_type NO_WORD = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = DATA_WR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   // Row currently presented; updated with the request fields so the monitor
   // sees the same word that the DUT sees.
   stim_row_type req_row = '0;

   // Predictor copy of the sound unit.
   logic [7:0]  sound_ram [wtsnd_pkg::RAM_BYTES];
   logic [6:0]  port_ptr;
   logic        port_autoinc;
   logic [2:0]  cur_ch;
   logic [2:0]  low_ch;

   sound_word_type pending_words [$];
   stim_row_type   stim_words [$];
   int             mismatch_count = 0;

   wavetable_sound_ram_channel_step_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed part. Channel 0's block gets all-ones: max frequency, max phase,
   // shortest wave (4 samples), offset 0xFF, volume 15. Its tick wraps the
   // phase modulo the wave length and the index wraps past the wave into byte 1,
   // whose low nibble is zero, so the level hits the -120 extreme.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{DATA_RD, 8'h00, 1'b1, '{1'b0, 8'h00, 3'd0, 8'sd0}},  // RAM clear after reset
      '{TICK,    8'h00, 1'b1, '{1'b1, 8'h00, 3'd7, 8'sd0}},  // one channel: 0 wraps to 7
      '{ADDR_WR, 8'hFF, 1'b0, NO_WORD},                      // autoinc, pointer 0x7F
      '{DATA_WR, 8'h70, 1'b0, NO_WORD},                      // all 8 channels, ptr wraps
      '{DATA_RD, 8'h00, 1'b1, '{1'b0, 8'h00, 3'd0, 8'sd0}},  // byte 0 after the wrap
      '{ADDR_WR, 8'hC0, 1'b0, NO_WORD},                      // autoinc, channel 0 block
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{DATA_WR, 8'hFF, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b1, '{1'b1, 8'h00, 3'd6, 8'sd0}},  // empty block, silent
      '{TICK,    8'hFF, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b0, NO_WORD},
      '{TICK,    8'h00, 1'b1, '{1'b1, 8'h00, 3'd0, -8'sd120}}, // channel 0, wrapped index
      '{TICK,    8'h00, 1'b1, '{1'b1, 8'h00, 3'd7, 8'sd0}},  // back to 7 after channel 0
      '{ADDR_WR, 8'h41, 1'b0, NO_WORD},                      // no autoinc, phase low byte
      '{DATA_RD, 8'h00, 1'b0, NO_WORD},
      '{DATA_RD, 8'h00, 1'b0, NO_WORD}                       // same byte again
   };

   function automatic void clear_sound();
      foreach (sound_ram[i]) sound_ram[i] = 8'h00;
      port_ptr     = '0;
      port_autoinc = 1'b0;
      cur_ch       = 3'd0;
      low_ch       = wtsnd_pkg::CH_TOP;
   endfunction

   // Applies one accepted word to the predictor; returns 1 with the expected
   // result for reads and ticks.
   function automatic bit step_sound(input logic [1:0] kind, input logic [7:0] data,
                                     output sound_word_type word);
      logic [6:0]  base;
      int unsigned phase;
      int unsigned freq;
      int unsigned wave_len;
      int unsigned index;
      logic [7:0]  sample_byte;
      logic [3:0]  nib;
      int          lvl;
      word = NO_WORD;
      case (kind)
         DATA_WR: begin
            sound_ram[port_ptr] = data;
            port_ptr = port_ptr + 7'(port_autoinc);
            low_ch = wtsnd_pkg::CH_TOP - sound_ram[wtsnd_pkg::CH_COUNT_ADDR][6:4];
            return 1'b0;
         end
         ADDR_WR: begin
            port_ptr     = data[6:0];
            port_autoinc = data[7];
            return 1'b0;
         end
         DATA_RD: begin
            word.read_byte = sound_ram[port_ptr];
            port_ptr = port_ptr + 7'(port_autoinc);
            return 1'b1;
         end
         default: begin
            cur_ch = cur_ch - 3'd1;
            if (cur_ch < low_ch) cur_ch = wtsnd_pkg::CH_TOP;
            base  = CH_BLOCKS | {1'b0, cur_ch, 3'b000};
            phase = 32'({sound_ram[base | OFS_PHASE2], sound_ram[base | OFS_PHASE1],
                         sound_ram[base | OFS_PHASE0]});
            freq  = 32'({sound_ram[base | OFS_LENGTH] & wtsnd_pkg::FREQ_HI_MASK,
                         sound_ram[base | OFS_FREQ1], sound_ram[base | OFS_FREQ0]});
            wave_len = 256 - int'(sound_ram[base | OFS_LENGTH] & wtsnd_pkg::LEN_MASK);
            phase = (phase + freq) % (wave_len << 16);
            sound_ram[base | OFS_PHASE2] = phase[23:16];
            sound_ram[base | OFS_PHASE1] = phase[15:8];
            sound_ram[base | OFS_PHASE0] = phase[7:0];
            // index wraps at 256 and may land on the channel registers
            index = ((phase >> 16) + 32'(sound_ram[base | OFS_WAVE])) & 32'hFF;
            sample_byte = sound_ram[index[7:1]];
            nib = index[0] ? sample_byte[7:4] : sample_byte[3:0];
            lvl = (int'(nib) - 8) * int'(sound_ram[base | OFS_VOLUME][3:0]);
            word.is_sample = 1'b1;
            word.channel   = cur_ch;
            word.level     = lvl[7:0];
            return 1'b1;
         end
      endcase
   endfunction

   function automatic void push_word(input logic [1:0] kind, input logic [7:0] data);
      stim_words.push_back('{kind, data, 1'b0, NO_WORD});
   endfunction

   // Random traffic as short, mostly well-formed sequences: channel block
   // programming, wave fills, channel count changes, tick bursts, read bursts,
   // write/read-back pairs, and some raw noise.
   function automatic void build_random_words();
      int          n;
      logic [2:0]  ch;
      logic [6:0]  addr;
      while (stim_words.size() < DIRECTED_ROWS + RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               ch = 3'($urandom_range(0, 7));
               push_word(ADDR_WR, {1'b1, CH_BLOCKS | {1'b0, ch, 3'b000}});
               for (int i = 0; i < 8; i++) push_word(DATA_WR, 8'($urandom));
            end
            2: begin
               push_word(ADDR_WR, {1'b1, 7'($urandom_range(0, 63))});
               n = $urandom_range(1, 8);
               for (int i = 0; i < n; i++) push_word(DATA_WR, 8'($urandom));
            end
            3: begin
               push_word(ADDR_WR, {1'($urandom), wtsnd_pkg::CH_COUNT_ADDR});
               push_word(DATA_WR, 8'($urandom));
            end
            4, 5, 6: begin
               n = $urandom_range(1, 12);
               for (int i = 0; i < n; i++) push_word(TICK, 8'($urandom));
            end
            7: begin
               push_word(ADDR_WR, 8'($urandom));
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++) push_word(DATA_RD, 8'($urandom));
            end
            8: begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++) push_word(2'($urandom), 8'($urandom));
            end
            default: begin
               addr = 7'($urandom);
               push_word(ADDR_WR, {1'($urandom), addr});
               push_word(DATA_WR, 8'($urandom));
               push_word(ADDR_WR, {1'($urandom), addr});
               push_word(DATA_RD, 8'($urandom));
            end
         endcase
      end
   endfunction

   // Idle length: mostly none or short, now and then long; zero in calm stretches.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Sender: reset, then walk the stimulus words; valid stays up across
   // back-to-back words and is only dropped for a gap.
   initial begin
      bit calm;
      int gap;
      calm = 1'b0;
      foreach (directed_rows[i]) stim_words.push_back(directed_rows[i]);
      build_random_words();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_words[i]) begin
         if ($urandom_range(0, 59) == 0) calm = !calm;
         gap = pick_gap(calm);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim_words[i].data;
         req_tuser  <= stim_words[i].kind;
         req_row    <= stim_words[i];
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("wavetable_sound_ram_channel_step_top verification clean");
      end else begin
         $display("wavetable_sound_ram_channel_step_top verification failed");
      end
      $finish;
   end

   // Receiver: random stalls of the same shape as the sender's gaps.
   int  stall_left = 0;
   bit  rsp_calm   = 1'b0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 79) == 0) rsp_calm <= !rsp_calm;
         if ($urandom_range(0, 2) == 0) stall_left <= pick_gap(rsp_calm);
      end
   end

   // Monitor: predict on every accepted request word first, then check the
   // accepted result word against the oldest expectation.
   always @(posedge clock) begin
      sound_word_type predicted;
      sound_word_type expected;
      sound_word_type actual;
      if (reset) begin
         clear_sound();
      end else begin
         if (req_tvalid && req_tready) begin
            if (step_sound(req_tuser, req_tdata, predicted))
               pending_words.push_back(req_row.typed ? req_row.word : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            actual = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tdata[18:11]};
            if (pending_words.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: unexpected word smp=%0d byte=%h ch=%0d lvl=%0d", $realtime,
                           actual.is_sample, actual.read_byte, actual.channel, actual.level);
            end else begin
               expected = pending_words.pop_front();
               if (actual.is_sample !== expected.is_sample ||
                   actual.read_byte !== expected.read_byte ||
                   actual.channel   !== expected.channel   ||
                   actual.level     !== expected.level) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < MAX_REPORTS)
                     $display({"%0t: mismatch exp smp=%0d byte=%h ch=%0d lvl=%0d, ",
                               "got smp=%0d byte=%h ch=%0d lvl=%0d"},
                              $realtime, expected.is_sample, expected.read_byte,
                              expected.channel, expected.level, actual.is_sample,
                              actual.read_byte, actual.channel, actual.level);
               end
            end
         end
      end
   end

   // Hang guard: well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("wavetable_sound_ram_channel_step_top verification failed");
      $finish;
   end

endmodule
`default_nettype wire
